// ===== sv/rcgr_pkg.sv =====
`default_nettype none
package rcgr_pkg;

   localparam int unsigned GAIN_W   = 16;
   localparam int unsigned CURVE_W  = 13;
   localparam int unsigned CSR_AW   = 3;
   localparam int unsigned CSR_DW   = 32;

   localparam logic [GAIN_W-1:0]  UNITY_GAIN      = 16'd4096;
   localparam logic [GAIN_W-1:0]  TARGET_RESET    = 16'd8192;
   localparam logic [GAIN_W-1:0]  FADE_RESET      = 16'd400;
   localparam logic [CURVE_W-1:0] CURVE_ONE       = 13'd4096;

   // register index is paddr[2]
   localparam logic REG_TARGET_GAIN = 1'b0;
   localparam logic REG_FADE_TIME   = 1'b1;

   localparam logic [63:0] Q30_ONE  = 64'd1073741824;
   localparam logic [63:0] PI_Q30   = 64'd3373259426;
   localparam logic [63:0] Q30_HALF_LSB = 64'd262144;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_DIV_START,
      ST_DIVIDE,
      ST_LOOKUP,
      ST_SCALE,
      ST_DELIVER
   } state_type;

   // raised cosine (1 - cos(pi*idx/n)) / 2 in q12, evaluated at elaboration
   function automatic logic [CURVE_W-1:0] curve_value(input logic [CURVE_W-1:0] idx,
                                                      input int unsigned bits);
      logic [63:0] n;
      logic [63:0] twice;
      logic [63:0] a;
      logic [63:0] z;
      logic [63:0] z2;
      logic [63:0] h;
      logic [63:0] s;
      logic [63:0] r;
      n     = 64'd1 << bits;
      twice = {50'd0, idx, 1'b0};
      a     = (twice >= n) ? (twice - n) : (n - twice);
      z     = (PI_Q30 * a) >> (bits + 1);
      z2    = (z * z) >> 30;
      h     = Q30_ONE - z2 / 64'd72;
      h     = Q30_ONE - ((z2 * h) >> 30) / 64'd42;
      h     = Q30_ONE - ((z2 * h) >> 30) / 64'd20;
      h     = Q30_ONE - ((z2 * h) >> 30) / 64'd6;
      s     = (z * h) >> 30;
      if (s > Q30_ONE) begin
         s = Q30_ONE;
      end
      if (twice >= n) begin
         r = (Q30_ONE + s + Q30_HALF_LSB) >> 19;
      end else begin
         r = (Q30_ONE - s + Q30_HALF_LSB) >> 19;
      end
      return r[CURVE_W-1:0];
   endfunction

endpackage
`default_nettype wire

// ===== sv/rcgr_divider.sv =====
`default_nettype none
module rcgr_divider #(
   parameter int unsigned CURVE_TABLE_BITS = 10
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [15:0]                 dividend,
   input  wire logic [15:0]                 divisor,
   output logic                             done,
   output logic [CURVE_TABLE_BITS:0]        quotient
);
   import rcgr_pkg::*;

   localparam int unsigned CW = $clog2(CURVE_TABLE_BITS + 1);

   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic [CW-1:0]             count_ff, count_in;
   logic [15:0]               rem_ff, rem_in;
   logic [CURVE_TABLE_BITS:0] quot_ff, quot_in;
   logic [16:0]               trial;
   logic                      fits;

   // one compare-subtract per cycle, one quotient bit per step
   always_comb begin
      trial    = {rem_ff, 1'b0};
      fits     = trial >= {1'b0, divisor};
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      quot_in  = quot_ff;
      if (start) begin
         if (dividend >= divisor) begin
            quot_in = (CURVE_TABLE_BITS+1)'(1) << CURVE_TABLE_BITS;
            done_in = 1'b1;
            busy_in = 1'b0;
         end else begin
            rem_in   = dividend;
            quot_in  = '0;
            count_in = CW'(CURVE_TABLE_BITS);
            busy_in  = 1'b1;
         end
      end else if (busy_ff) begin
         rem_in   = fits ? 16'(trial - {1'b0, divisor}) : trial[15:0];
         quot_in  = {quot_ff[CURVE_TABLE_BITS-1:0], fits};
         count_in = count_ff - CW'(1);
         if (count_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule
`default_nettype wire

// ===== sv/rcgr_curve_rom.sv =====
`default_nettype none
module rcgr_curve_rom #(
   parameter int unsigned CURVE_TABLE_BITS = 10
) (
   input  wire logic                          clock,
   input  wire logic [CURVE_TABLE_BITS:0]     idx,
   output logic [rcgr_pkg::CURVE_W-1:0]       curve
);
   import rcgr_pkg::*;

   localparam int unsigned DEPTH = (1 << CURVE_TABLE_BITS) + 1;

   typedef logic [CURVE_W-1:0] curve_table_type [DEPTH];

   function automatic curve_table_type build_table();
      curve_table_type t;
      for (int i = 0; i < DEPTH; i++) begin
         t[i] = curve_value(CURVE_W'(i), CURVE_TABLE_BITS);
      end
      return t;
   endfunction

   localparam curve_table_type CURVE_TABLE = build_table();

   logic [CURVE_W-1:0] curve_ff;

   always_ff @(posedge clock) begin
      curve_ff <= CURVE_TABLE[idx];
   end

   assign curve = curve_ff;

endmodule
`default_nettype wire

// ===== sv/rcgr_gain_scale.sv =====
`default_nettype none
module rcgr_gain_scale (
   input  wire logic                          clock,
   input  wire logic [rcgr_pkg::CURVE_W-1:0]  curve,
   input  wire logic [rcgr_pkg::GAIN_W-1:0]   target_gain,
   output logic [rcgr_pkg::GAIN_W-1:0]        gain
);
   import rcgr_pkg::*;

   logic [GAIN_W-1:0] gain_ff;
   logic [GAIN_W-1:0] gain_in;
   logic [29:0]       sum;

   // unity * (1 - curve) + target * curve, rounded
   always_comb begin
      sum = ({17'd0, 13'(CURVE_ONE - curve)} << 12)
            + (30'(target_gain) * 30'(curve))
            + 30'd2048;
      gain_in = sum[27:12];
   end

   always_ff @(posedge clock) begin
      gain_ff <= gain_in;
   end

   assign gain = gain_ff;

endmodule
`default_nettype wire

// ===== sv/raised_cosine_gain_ramp.sv =====
// sequence: a tick that holds the gain goes from the update step straight to delivery;
//   otherwise it passes through divider start, the serial divide, curve lookup and gain
//   scaling; a saturating quotient skips the serial steps; the divider takes one quotient bit per cycle
// flow: one tick at a time, the next is taken once the result is registered, in the
//   idle state that follows delivery; a stalled result holds input
// reset: synchronous, clears position to zero, gain to unity and registers to defaults
`default_nettype none
module raised_cosine_gain_ramp #(
   parameter int unsigned CURVE_TABLE_BITS = 10
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   input  wire logic [15:0]                 req_tdata,   // elapsed_ms
   input  wire logic                        req_tuser,   // overdrive_on
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   output logic [15:0]                      rsp_tdata,   // gain
   output logic                             rsp_tuser,   // at_end
   input  wire logic                        csr_psel,
   input  wire logic                        csr_penable,
   input  wire logic                        csr_pwrite,
   input  wire logic [rcgr_pkg::CSR_AW-1:0] csr_paddr,
   input  wire logic [rcgr_pkg::CSR_DW-1:0] csr_pwdata,
   output logic [rcgr_pkg::CSR_DW-1:0]      csr_prdata,
   output logic                             csr_pready
);
   import rcgr_pkg::*;

   state_type         state_ff, state_in;
   logic [15:0]       target_ff, target_in;
   logic [15:0]       fade_cfg_ff, fade_cfg_in;
   logic [15:0]       fade_ff, fade_in;
   logic [15:0]       pos_ff, pos_in;
   logic [15:0]       held_ff, held_in;
   logic [15:0]       dt_ff, dt_in;
   logic              on_ff, on_in;
   logic              hold_ff, hold_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [15:0]       rsp_gain_ff, rsp_gain_in;
   logic              rsp_end_ff, rsp_end_in;

   logic              csr_write;
   logic              accept;
   logic              load_rsp;
   logic              div_start;
   logic              div_done;
   logic [CURVE_TABLE_BITS:0] quotient;
   logic [CURVE_W-1:0] curve;
   logic [15:0]       gain;
   logic [16:0]       sum17;
   logic [15:0]       up_pos;
   logic [15:0]       down_pos;
   logic              hold_now;

   rcgr_divider #(.CURVE_TABLE_BITS(CURVE_TABLE_BITS)) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (pos_ff),
      .divisor  (fade_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   rcgr_curve_rom #(.CURVE_TABLE_BITS(CURVE_TABLE_BITS)) u_curve_rom (
      .clock (clock),
      .idx   (quotient),
      .curve (curve)
   );

   rcgr_gain_scale u_gain_scale (
      .clock       (clock),
      .curve       (curve),
      .target_gain (target_ff),
      .gain        (gain)
   );

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      unique case (csr_paddr[2])
         REG_TARGET_GAIN: csr_prdata = {16'd0, target_ff};
         REG_FADE_TIME:   csr_prdata = {16'd0, fade_cfg_ff};
         default:         csr_prdata = '0;
      endcase
   end

   assign sum17    = {1'b0, pos_ff} + {1'b0, dt_ff};
   assign up_pos   = (sum17 < {1'b0, fade_ff}) ? sum17[15:0] : fade_ff;
   assign down_pos = (pos_ff > dt_ff) ? 16'(pos_ff - dt_ff) : 16'd0;
   assign hold_now = on_ff ? (pos_ff == fade_ff) : (pos_ff == 16'd0);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:      if (req_tvalid) state_in = ST_UPDATE;
         ST_UPDATE:    state_in = hold_now ? ST_DELIVER : ST_DIV_START;
         ST_DIV_START: state_in = ST_DIVIDE;
         ST_DIVIDE:    if (div_done) state_in = ST_LOOKUP;
         ST_LOOKUP:    state_in = ST_SCALE;
         ST_SCALE:     state_in = ST_DELIVER;
         ST_DELIVER:   if (!rsp_valid_ff || rsp_tready) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      req_tready   = (state_ff == ST_IDLE);
      accept       = req_tvalid && req_tready;
      div_start    = (state_ff == ST_DIV_START);
      load_rsp     = (state_ff == ST_DELIVER) && (!rsp_valid_ff || rsp_tready);
      target_in    = target_ff;
      fade_cfg_in  = fade_cfg_ff;
      fade_in      = fade_ff;
      pos_in       = pos_ff;
      held_in      = held_ff;
      dt_in        = dt_ff;
      on_in        = on_ff;
      hold_in      = hold_ff;
      rsp_gain_in  = rsp_gain_ff;
      rsp_end_in   = rsp_end_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (csr_write) begin
         unique case (csr_paddr[2])
            REG_TARGET_GAIN: target_in   = csr_pwdata[15:0];
            REG_FADE_TIME:   fade_cfg_in = csr_pwdata[15:0];
            default:         target_in   = target_ff;
         endcase
      end
      if (accept) begin
         dt_in   = req_tdata;
         on_in   = req_tuser;
         fade_in = (fade_cfg_ff == 16'd0) ? 16'd1 : fade_cfg_ff;
      end
      if (state_ff == ST_UPDATE) begin
         hold_in = hold_now;
         if (!hold_now) begin
            pos_in = on_ff ? up_pos : down_pos;
         end
      end
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         if (hold_ff) begin
            rsp_gain_in = held_ff;
            rsp_end_in  = 1'b1;
         end else begin
            rsp_gain_in = gain;
            rsp_end_in  = (pos_ff == 16'd0) || (pos_ff == fade_ff);
            held_in     = gain;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         target_ff    <= TARGET_RESET;
         fade_cfg_ff  <= FADE_RESET;
         pos_ff       <= 16'd0;
         held_ff      <= UNITY_GAIN;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         target_ff    <= target_in;
         fade_cfg_ff  <= fade_cfg_in;
         pos_ff       <= pos_in;
         held_ff      <= held_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      fade_ff     <= fade_in;
      dt_ff       <= dt_in;
      on_ff       <= on_in;
      hold_ff     <= hold_in;
      rsp_gain_ff <= rsp_gain_in;
      rsp_end_ff  <= rsp_end_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_gain_ff;
   assign rsp_tuser  = rsp_end_ff;

`ifndef SYNTHESIS
   a_pos_clamped: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV_START && on_ff) |-> (pos_ff <= fade_ff))
      else $error("position beyond fade time while rising");

   a_done_in_divide: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIVIDE))
      else $error("divider finished outside the divide step");

   a_quotient_range: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (quotient <= ((CURVE_TABLE_BITS+1)'(1) << CURVE_TABLE_BITS)))
      else $error("quotient above table range");

   a_rsp_from_deliver: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_DELIVER))
      else $error("result beat raised outside delivery");

   a_end_on_hold: assert property (@(posedge clock) disable iff (reset)
      (load_rsp && hold_ff) |=> (rsp_end_ff && rsp_gain_ff == held_ff))
      else $error("held tick did not return the held gain");
`endif

endmodule
`default_nettype wire

// ===== verif/raised_cosine_gain_ramp_tb.sv =====
`timescale 1ns / 100ps

module raised_cosine_gain_ramp_tb;

   localparam int unsigned CURVE_BITS     = 10;
   localparam int unsigned STALL_MAX      = 14;
   localparam int unsigned SETTLE_CYCLES  = 24;
   localparam int unsigned WATCHDOG_LIMIT = 2000;
   localparam int unsigned PRESSURE_HOLD  = 400;
   localparam int unsigned RANDOM_PHASES  = 8;
   localparam int unsigned PHASE_TICKS    = 90;
   localparam int unsigned REPORT_LIMIT   = 50;

   typedef struct packed {
      logic [15:0] gain;
      logic        at_end;
   } gain_beat_type;

   logic                            clock = 1'b0;
   logic                            reset;
   logic                            req_tvalid;
   logic                            req_tready;
   logic [15:0]                     req_tdata;   // elapsed_ms
   logic                            req_tuser;   // overdrive_on
   logic                            rsp_tvalid;
   logic                            rsp_tready;
   logic [15:0]                     rsp_tdata;   // gain
   logic                            rsp_tuser;   // at_end
   logic                            csr_psel;
   logic                            csr_penable;
   logic                            csr_pwrite;
   logic [rcgr_pkg::CSR_AW-1:0]     csr_paddr;
   logic [rcgr_pkg::CSR_DW-1:0]     csr_pwdata;
   logic [rcgr_pkg::CSR_DW-1:0]     csr_prdata;
   logic                            csr_pready;

   // envelope mirror
   logic [15:0]    target_mirror;
   logic [15:0]    fade_mirror;
   int unsigned    position_ms;
   logic [15:0]    held_gain_mirror;
   gain_beat_type  expected_gains[$];

   bit           idle_on;
   int unsigned  hold_request;
   int unsigned  errors;
   int unsigned  ticks_sent;
   int unsigned  results_checked;
   int unsigned  held_count;
   int unsigned  writes_done;
   int unsigned  idle_count;

   raised_cosine_gain_ramp #(
      .CURVE_TABLE_BITS(CURVE_BITS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      if (errors < REPORT_LIMIT) begin
         $display("%0t mismatch: %s", $time, msg);
      end
      errors++;
   endtask

   // (1 - cos(pi*idx/n)) / 2 in q12, odd taylor series for the sine about the midpoint
   function automatic int unsigned raised_cosine_q12(input int unsigned idx);
      longint unsigned one;
      longint unsigned span;
      longint unsigned dbl;
      longint unsigned offset;
      longint unsigned ang;
      longint unsigned ang2;
      longint unsigned poly;
      longint unsigned sine;
      one    = rcgr_pkg::Q30_ONE;
      span   = 64'd1 << CURVE_BITS;
      dbl    = 2 * longint'(idx);
      offset = (dbl >= span) ? dbl - span : span - dbl;
      ang    = (rcgr_pkg::PI_Q30 * offset) / (2 * span);
      ang2   = (ang * ang) >> 30;
      poly   = one - ang2 / 72;
      poly   = one - ((ang2 * poly) >> 30) / 42;
      poly   = one - ((ang2 * poly) >> 30) / 20;
      poly   = one - ((ang2 * poly) >> 30) / 6;
      sine   = (ang * poly) >> 30;
      if (sine > one) begin
         sine = one;
      end
      if (dbl >= span) begin
         return 32'((one + sine + rcgr_pkg::Q30_HALF_LSB) >> 19);
      end else begin
         return 32'((one - sine + rcgr_pkg::Q30_HALF_LSB) >> 19);
      end
   endfunction

   function automatic void predict_tick(input logic [15:0] dt, input logic on);
      int unsigned     fade;
      int unsigned     idx;
      int unsigned     curve;
      longint unsigned mix;
      logic            holding;
      gain_beat_type   beat;
      fade    = (fade_mirror == 16'd0) ? 1 : fade_mirror;
      holding = on ? (position_ms == fade) : (position_ms == 0);
      if (holding) begin
         held_count++;
      end else begin
         if (on) begin
            position_ms = (position_ms + dt < fade) ? position_ms + dt : fade;
         end else begin
            position_ms = (position_ms > dt) ? position_ms - dt : 0;
         end
         idx = (position_ms << CURVE_BITS) / fade;
         if (idx > (1 << CURVE_BITS)) begin
            idx = 1 << CURVE_BITS;
         end
         curve = raised_cosine_q12(idx);
         mix = 64'(rcgr_pkg::UNITY_GAIN) * (4096 - curve) + 64'(target_mirror) * curve + 2048;
         held_gain_mirror = 16'(mix >> 12);
      end
      beat.gain   = held_gain_mirror;
      beat.at_end = (position_ms == 0) || (position_ms == fade);
      expected_gains.push_back(beat);
   endfunction

   task automatic offer_tick(input logic [15:0] dt, input logic on);
      int unsigned gap;
      gap = idle_on ? $urandom_range(STALL_MAX, 0) : 0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= dt;
      req_tuser  <= on;
      do @(posedge clock); while (!req_tready);
      predict_tick(dt, on);
      ticks_sent++;
   endtask

   task automatic settle_envelope();
      req_tvalid <= 1'b0;
      while (expected_gains.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic check_register(input logic which);
      logic [15:0] want;
      want = (which == rcgr_pkg::REG_TARGET_GAIN) ? target_mirror : fade_mirror;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {which, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== 32'(want)) begin
         report_mismatch($sformatf("register %0d reads %0h, expected %0h",
                                   which, csr_prdata, want));
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_register(input logic which, input logic [15:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {which, 2'b00};
      csr_pwdata  <= 32'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      if (which == rcgr_pkg::REG_TARGET_GAIN) begin
         target_mirror = value;
      end else begin
         fade_mirror = value;
      end
      writes_done++;
      check_register(which);
   endtask

   // mostly runs in one direction with steps scaled to the fade time, some noise ticks
   task automatic run_random_ticks(input int unsigned count);
      int unsigned sent;
      int unsigned run_len;
      int unsigned step_max;
      logic        dir;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(4, 0) == 0) begin
            offer_tick(16'($urandom()), 1'($urandom()));
            sent++;
         end else begin
            dir      = 1'($urandom());
            run_len  = $urandom_range(12, 1);
            step_max = ((fade_mirror == 16'd0) ? 1 : fade_mirror) / 4 + 1;
            for (int i = 0; i < run_len && sent < count; i++) begin
               offer_tick(16'($urandom_range(step_max, 0)), dir);
               sent++;
            end
         end
      end
   endtask

   task automatic test_reset_defaults();
      idle_on = 1;
      check_register(rcgr_pkg::REG_TARGET_GAIN);
      check_register(rcgr_pkg::REG_FADE_TIME);
      offer_tick(16'd0, 1'b0);
      offer_tick(16'd0, 1'b1);
      offer_tick(16'd1, 1'b1);
      offer_tick(16'd199, 1'b1);
      offer_tick(16'hFFFF, 1'b1);
      offer_tick(16'd123, 1'b1);
      offer_tick(16'hFFFF, 1'b0);
      offer_tick(16'd7, 1'b0);
      settle_envelope();
   endtask

   task automatic test_extreme_settings();
      write_register(rcgr_pkg::REG_TARGET_GAIN, 16'hFFFF);
      write_register(rcgr_pkg::REG_FADE_TIME, 16'hFFFF);
      offer_tick(16'hFFFF, 1'b1);
      offer_tick(16'd0, 1'b1);
      offer_tick(16'd1, 1'b0);
      settle_envelope();
      write_register(rcgr_pkg::REG_TARGET_GAIN, 16'd0);
      offer_tick(16'hFFFF, 1'b0);
      offer_tick(16'h8000, 1'b1);
      offer_tick(16'hFFFF, 1'b1);
      settle_envelope();
   endtask

   task automatic test_fade_lowered();
      write_register(rcgr_pkg::REG_TARGET_GAIN, 16'd12288);
      write_register(rcgr_pkg::REG_FADE_TIME, 16'd1000);
      offer_tick(16'hFFFF, 1'b0);
      offer_tick(16'd800, 1'b1);
      settle_envelope();
      // overdrive on snaps the position down to the new fade time
      write_register(rcgr_pkg::REG_FADE_TIME, 16'd300);
      offer_tick(16'd5, 1'b1);
      settle_envelope();
      write_register(rcgr_pkg::REG_FADE_TIME, 16'd1000);
      offer_tick(16'd600, 1'b1);
      settle_envelope();
      // falling from above the fade time, quotient saturates
      write_register(rcgr_pkg::REG_FADE_TIME, 16'd300);
      offer_tick(16'd100, 1'b0);
      offer_tick(16'd400, 1'b0);
      offer_tick(16'd200, 1'b0);
      settle_envelope();
   endtask

   task automatic test_zero_fade();
      write_register(rcgr_pkg::REG_TARGET_GAIN, 16'd20000);
      write_register(rcgr_pkg::REG_FADE_TIME, 16'd0);
      offer_tick(16'hFFFF, 1'b0);
      offer_tick(16'd0, 1'b1);
      offer_tick(16'd1, 1'b1);
      offer_tick(16'd9, 1'b1);
      offer_tick(16'd0, 1'b0);
      offer_tick(16'd3, 1'b0);
      settle_envelope();
   endtask

   task automatic test_backpressure();
      idle_on      = 0;
      hold_request = PRESSURE_HOLD;
      run_random_ticks(24);
      settle_envelope();
   endtask

   task automatic test_random_settings();
      logic [15:0] tg;
      logic [15:0] fd;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case ($urandom_range(3, 0))
            0: tg = 16'd0;
            1: tg = 16'hFFFF;
            default: tg = 16'($urandom());
         endcase
         case ($urandom_range(5, 0))
            0: fd = 16'($urandom_range(20, 1));
            1: fd = 16'($urandom_range(600, 21));
            2: fd = 16'($urandom_range(65535, 601));
            3: fd = 16'hFFFF;
            4: fd = 16'd0;
            default: fd = 16'($urandom_range(100, 1));
         endcase
         write_register(rcgr_pkg::REG_TARGET_GAIN, tg);
         write_register(rcgr_pkg::REG_FADE_TIME, fd);
         idle_on = ($urandom_range(3, 0) != 0);
         run_random_ticks(PHASE_TICKS);
         settle_envelope();
      end
   endtask

   // result side: random stalls, one long hold on request
   initial begin
      int unsigned   stall;
      gain_beat_type want;
      rsp_tready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_request != 0) begin
            stall = hold_request;
         end else begin
            stall = idle_on ? $urandom_range(STALL_MAX, 0) : 0;
         end
         hold_request = 0;
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         if (expected_gains.size() == 0) begin
            report_mismatch($sformatf("result beat gain %0h with no tick outstanding",
                                      rsp_tdata));
         end else begin
            want = expected_gains.pop_front();
            results_checked++;
            if (rsp_tdata !== want.gain) begin
               report_mismatch($sformatf("gain %0h, expected %0h", rsp_tdata, want.gain));
            end
            if (rsp_tuser !== want.at_end) begin
               report_mismatch($sformatf("at_end %0b, expected %0b", rsp_tuser, want.at_end));
            end
         end
      end
   end

   initial begin
      idle_count = 0;
      while (idle_count < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel) begin
            idle_count = 0;
         end else begin
            idle_count++;
         end
      end
      $display("timeout: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tuser   <= 1'b0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      target_mirror    = rcgr_pkg::TARGET_RESET;
      fade_mirror      = rcgr_pkg::FADE_RESET;
      position_ms      = 0;
      held_gain_mirror = rcgr_pkg::UNITY_GAIN;
      idle_on          = 1;
      hold_request     = 0;
      errors           = 0;
      ticks_sent       = 0;
      results_checked  = 0;
      held_count       = 0;
      writes_done      = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_extreme_settings();
      test_fade_lowered();
      test_zero_fade();
      test_backpressure();
      test_random_settings();
      settle_envelope();
      $display("covered %0d ticks (%0d held) over %0d register writes, with a long output hold",
               ticks_sent, held_count, writes_done);
      $display("%0d result beats checked, %0d mismatches", results_checked, errors);
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
sv/rcgr_pkg.sv
sv/rcgr_divider.sv
sv/rcgr_curve_rom.sv
sv/rcgr_gain_scale.sv
sv/raised_cosine_gain_ramp.sv
verif/raised_cosine_gain_ramp_tb.sv
